// ===== rtl/core/debug_breakpoint_slot_manager_macros.svh =====
// Assertion helpers for the breakpoint slot manager.
`ifndef DEBUG_BREAKPOINT_SLOT_MANAGER_MACROS_SVH
`define DEBUG_BREAKPOINT_SLOT_MANAGER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DBSM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dbsm assertion failed");

// Next-cycle implication, checked outside reset.
`define DBSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dbsm assertion failed");

`endif

// ===== rtl/core/dbsm_pkg.sv =====
package dbsm_pkg;

  localparam int unsigned HwSlotsDef = 4;
  localparam int unsigned SwSlotsDef = 16;

  localparam logic ActAdd    = 1'b0;
  localparam logic ActRemove = 1'b1;

  localparam logic [2:0] BpSoft   = 3'd0;
  localparam logic [2:0] BpHwExec = 3'd1;
  localparam logic [2:0] BpWrite  = 3'd2;
  localparam logic [2:0] BpRead   = 3'd3;
  localparam logic [2:0] BpAccess = 3'd4;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatMissing = 2'd1;
  localparam logic [1:0] StatFull    = 2'd2;

  typedef struct packed {
    logic        action;
    logic [2:0]  bp_type;
    logic [63:0] address;
    logic [3:0]  length;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] slot0_address;
    logic [63:0] slot1_address;
    logic [63:0] slot2_address;
    logic [63:0] slot3_address;
    logic [31:0] dr7_image;
    logic        debug_enable;
    logic        step_enable;
    logic        use_soft_bp;
    logic        use_hard_bp;
  } rsp_t;

  typedef struct packed {
    logic [3:0] len;
    logic [2:0] kind;
  } hw_attr_t;

  typedef struct packed {
    logic [63:0] addr;
    hw_attr_t    attr;
  } hw_entry_t;

  // Scan token travelling along the software cells.
  typedef struct packed {
    logic tok;
    logic found;
    logic free;
  } sw_link_t;

  typedef struct packed {
    logic tok;
    logic found;
  } hw_link_t;

  typedef struct packed {
    logic insert;
    logic clear;
  } sw_cmd_t;

  typedef struct packed {
    logic insert;
    logic remove;
  } hw_cmd_t;

  function automatic logic [1:0] dr7_len_enc(input logic [3:0] len);
    logic [1:0] code;
    unique case (len)
      4'd2:    code = 2'd1;
      4'd4:    code = 2'd3;
      4'd8:    code = 2'd2;
      default: code = 2'd0;
    endcase
    return code;
  endfunction

  // There is no read-only watch, so a read watch uses the read-or-write code.
  function automatic logic [1:0] dr7_kind_enc(input logic [2:0] kind);
    logic [1:0] code;
    unique case (kind) inside
      BpWrite:          code = 2'd1;
      BpRead, BpAccess: code = 2'd3;
      default:          code = 2'd0;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/core/dbsm_sw_cell.sv =====
module dbsm_sw_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dbsm_pkg::req_t    key_i,
  input  dbsm_pkg::sw_cmd_t cmd_i,
  input  dbsm_pkg::sw_link_t link_i,
  output dbsm_pkg::sw_link_t link_o
);

  logic        valid_q;
  logic [63:0] addr_q;
  logic [3:0]  len_q;
  logic        hit_mark_q;
  logic        free_mark_q;
  logic        tok_q;
  logic        found_q;
  logic        free_q;
  logic        hit;

  assign hit = valid_q && (addr_q == key_i.address) && (len_q == key_i.length);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      hit_mark_q  <= 1'b0;
      free_mark_q <= 1'b0;
      tok_q       <= 1'b0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
    end else begin
      tok_q <= link_i.tok;
      if (link_i.tok) begin
        // Only the first match and the first free entry along the row are marked.
        hit_mark_q  <= hit && !link_i.found;
        free_mark_q <= !valid_q && !link_i.free;
        found_q     <= link_i.found || hit;
        free_q      <= link_i.free || !valid_q;
      end
      if (cmd_i.insert && free_mark_q) begin
        valid_q <= 1'b1;
      end else if (cmd_i.clear && hit_mark_q) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert && free_mark_q) begin
      addr_q <= key_i.address;
      len_q  <= key_i.length;
    end
  end

  assign link_o = '{tok: tok_q, found: found_q, free: free_q};

endmodule

// ===== rtl/core/dbsm_hw_cell.sv =====
module dbsm_hw_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dbsm_pkg::req_t      key_i,
  input  logic                occ_i,
  input  dbsm_pkg::hw_cmd_t   cmd_i,
  input  dbsm_pkg::hw_link_t  link_i,
  output dbsm_pkg::hw_link_t  link_o,
  input  dbsm_pkg::hw_entry_t left_i,
  input  dbsm_pkg::hw_entry_t right_i,
  output dbsm_pkg::hw_entry_t entry_o
);

  dbsm_pkg::hw_entry_t entry_q;
  logic                shift_q;
  logic                tok_q;
  logic                found_q;
  logic                hit;

  assign hit = occ_i && (entry_q.addr == key_i.address) && (entry_q.attr.len == key_i.length);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 1'b0;
      tok_q   <= 1'b0;
      found_q <= 1'b0;
    end else begin
      tok_q <= link_i.tok;
      if (link_i.tok) begin
        // Cells from the matching one onwards pull from the right to close the gap.
        shift_q <= link_i.found || hit;
        found_q <= link_i.found || hit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      entry_q <= left_i;
    end else if (cmd_i.remove && shift_q) begin
      entry_q <= right_i;
    end
  end

  assign link_o  = '{tok: tok_q, found: found_q};
  assign entry_o = entry_q;

endmodule

// ===== rtl/core/debug_breakpoint_slot_manager.sv =====
// Channel   Direction  Handshake               Payload
// in        request    in_valid_i / in_stall_o  in_req_i   (dbsm_pkg::req_t)
// out       result     out_valid_o / out_stall_i out_rsp_o (dbsm_pkg::rsp_t)
// cfg       write      cfg_valid_i / cfg_ready_o cfg_data_i (single_step)
//
// From acceptance until its result is loaded, a request waits on the scan token,
// which walks each row of cells one cell per cycle; the longer row decides.
// Reset empties both tables and clears single_step; no clearing pass is needed.
// A waiting result does not block the next request, but a finished request
// holds in its last step until the output register is free.
`include "debug_breakpoint_slot_manager_macros.svh"

module debug_breakpoint_slot_manager #(
  parameter int unsigned HW_SLOTS = dbsm_pkg::HwSlotsDef,
  parameter int unsigned SW_SLOTS = dbsm_pkg::SwSlotsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  dbsm_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output dbsm_pkg::rsp_t out_rsp_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_data_i
);

  localparam int unsigned HwCntW = $clog2(HW_SLOTS + 1);
  localparam int unsigned SwCntW = $clog2(SW_SLOTS + 1);

  typedef enum logic [2:0] {
    StIdle,
    StLaunch,
    StScan,
    StCommit,
    StBuild
  } state_e;

  state_e            state_q;
  dbsm_pkg::req_t    key_q;
  logic              single_step_q;
  logic [HwCntW-1:0] hw_used_q;
  logic [SwCntW-1:0] sw_cnt_q;
  logic              sw_done_q, sw_found_q, sw_free_q;
  logic              hw_done_q, hw_found_q;
  logic [1:0]        status_q;
  dbsm_pkg::sw_cmd_t sw_cmd_q;
  dbsm_pkg::hw_cmd_t hw_cmd_q;
  logic              out_valid_q;
  dbsm_pkg::rsp_t    rsp_q;

  dbsm_pkg::sw_link_t  sw_link [SW_SLOTS+1];
  dbsm_pkg::hw_link_t  hw_link [HW_SLOTS+1];
  dbsm_pkg::hw_entry_t hw_ent  [HW_SLOTS];
  dbsm_pkg::hw_entry_t key_ent;
  logic [HW_SLOTS-1:0] occ;

  logic [63:0] slot_addr [4];
  logic [31:0] slot_dr7  [4];

  logic        is_sw, is_hw, hw_full, load_out;
  logic [1:0]  status_d;
  dbsm_pkg::sw_cmd_t sw_cmd_d;
  dbsm_pkg::hw_cmd_t hw_cmd_d;
  dbsm_pkg::rsp_t    rsp_d;
  logic [31:0] dr7_d;
  logic        sw_any, hard;

  assign in_stall_o  = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  assign key_ent = '{addr: key_q.address, attr: '{len: key_q.length, kind: key_q.bp_type}};

  // The scan token enters the first cell of each row in the launch cycle.
  assign sw_link[0] = '{tok: (state_q == StLaunch), found: 1'b0, free: 1'b0};
  assign hw_link[0] = '{tok: (state_q == StLaunch), found: 1'b0};

  for (genvar i = 0; i < SW_SLOTS; i++) begin : g_sw
    dbsm_sw_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .key_i  (key_q),
      .cmd_i  (sw_cmd_q),
      .link_i (sw_link[i]),
      .link_o (sw_link[i+1])
    );
  end

  for (genvar i = 0; i < HW_SLOTS; i++) begin : g_hw
    assign occ[i] = (hw_used_q > HwCntW'(i));
    dbsm_hw_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .key_i   (key_q),
      .occ_i   (occ[i]),
      .cmd_i   (hw_cmd_q),
      .link_i  (hw_link[i]),
      .link_o  (hw_link[i+1]),
      .left_i  ((i == 0) ? key_ent : hw_ent[(i == 0) ? 0 : i - 1]),
      .right_i ((i == HW_SLOTS - 1) ? hw_ent[i] : hw_ent[(i == HW_SLOTS - 1) ? i : i + 1]),
      .entry_o (hw_ent[i])
    );
  end

  for (genvar n = 0; n < 4; n++) begin : g_slot
    if (n < HW_SLOTS) begin : g_used
      always_comb begin
        slot_addr[n] = '0;
        slot_dr7[n]  = '0;
        if (occ[n]) begin
          slot_addr[n]              = hw_ent[n].addr;
          slot_dr7[n][2*n+1]        = 1'b1;
          slot_dr7[n][16+4*n +: 2]  = dbsm_pkg::dr7_kind_enc(hw_ent[n].attr.kind);
          slot_dr7[n][18+4*n +: 2]  = dbsm_pkg::dr7_len_enc(hw_ent[n].attr.len);
        end
      end
    end else begin : g_none
      assign slot_addr[n] = '0;
      assign slot_dr7[n]  = '0;
    end
  end

  assign sw_any = (sw_cnt_q != '0);
  assign hard   = (hw_used_q != '0);

  always_comb begin
    dr7_d = '0;
    if (hard) begin
      dr7_d[9]  = 1'b1;
      dr7_d[10] = 1'b1;
      for (int n = 0; n < 4; n++) begin
        dr7_d = dr7_d | slot_dr7[n];
      end
    end
    rsp_d = '{
      status:        status_q,
      slot0_address: slot_addr[0],
      slot1_address: slot_addr[1],
      slot2_address: slot_addr[2],
      slot3_address: slot_addr[3],
      dr7_image:     dr7_d,
      debug_enable:  single_step_q || sw_any || hard,
      step_enable:   single_step_q,
      use_soft_bp:   sw_any,
      use_hard_bp:   hard
    };
  end

  // Outcome of the request once both rows have been scanned.
  assign is_sw   = (key_q.bp_type == dbsm_pkg::BpSoft);
  assign is_hw   = (key_q.bp_type >= dbsm_pkg::BpHwExec) &&
                   (key_q.bp_type <= dbsm_pkg::BpAccess);
  assign hw_full = (hw_used_q == HwCntW'(HW_SLOTS));

  always_comb begin
    status_d = dbsm_pkg::StatMissing;
    sw_cmd_d = '0;
    hw_cmd_d = '0;
    if (is_sw) begin
      if (key_q.action == dbsm_pkg::ActAdd) begin
        if (sw_found_q) begin
          status_d = dbsm_pkg::StatOk;
        end else if (sw_free_q) begin
          status_d        = dbsm_pkg::StatOk;
          sw_cmd_d.insert = 1'b1;
        end else begin
          status_d = dbsm_pkg::StatFull;
        end
      end else if (sw_found_q) begin
        status_d       = dbsm_pkg::StatOk;
        sw_cmd_d.clear = 1'b1;
      end
    end else if (is_hw) begin
      if (key_q.action == dbsm_pkg::ActAdd) begin
        if (hw_found_q) begin
          status_d = dbsm_pkg::StatOk;
        end else if (hw_full) begin
          status_d = dbsm_pkg::StatFull;
        end else begin
          status_d        = dbsm_pkg::StatOk;
          hw_cmd_d.insert = 1'b1;
        end
      end else if (hw_found_q) begin
        status_d        = dbsm_pkg::StatOk;
        hw_cmd_d.remove = 1'b1;
      end
    end
  end

  assign load_out = (state_q == StBuild) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      key_q         <= '0;
      single_step_q <= 1'b0;
      hw_used_q     <= '0;
      sw_cnt_q      <= '0;
      sw_done_q     <= 1'b0;
      sw_found_q    <= 1'b0;
      sw_free_q     <= 1'b0;
      hw_done_q     <= 1'b0;
      hw_found_q    <= 1'b0;
      status_q      <= dbsm_pkg::StatOk;
      sw_cmd_q      <= '0;
      hw_cmd_q      <= '0;
      out_valid_q   <= 1'b0;
      rsp_q         <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        single_step_q <= cfg_data_i;
      end

      if (load_out) begin
        out_valid_q <= 1'b1;
        rsp_q       <= rsp_d;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            key_q   <= in_req_i;
            state_q <= StLaunch;
          end
        end
        StLaunch: begin
          sw_done_q <= 1'b0;
          hw_done_q <= 1'b0;
          state_q   <= StScan;
        end
        StScan: begin
          if (sw_link[SW_SLOTS].tok) begin
            sw_done_q  <= 1'b1;
            sw_found_q <= sw_link[SW_SLOTS].found;
            sw_free_q  <= sw_link[SW_SLOTS].free;
          end
          if (hw_link[HW_SLOTS].tok) begin
            hw_done_q  <= 1'b1;
            hw_found_q <= hw_link[HW_SLOTS].found;
          end
          if (sw_done_q && hw_done_q) begin
            status_q <= status_d;
            sw_cmd_q <= sw_cmd_d;
            hw_cmd_q <= hw_cmd_d;
            state_q  <= StCommit;
          end
        end
        StCommit: begin
          if (sw_cmd_q.insert) begin
            sw_cnt_q <= sw_cnt_q + SwCntW'(1);
          end else if (sw_cmd_q.clear) begin
            sw_cnt_q <= sw_cnt_q - SwCntW'(1);
          end
          if (hw_cmd_q.insert) begin
            hw_used_q <= hw_used_q + HwCntW'(1);
          end else if (hw_cmd_q.remove) begin
            hw_used_q <= hw_used_q - HwCntW'(1);
          end
          sw_cmd_q <= '0;
          hw_cmd_q <= '0;
          state_q  <= StBuild;
        end
        StBuild: begin
          if (load_out) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  `DBSM_ASSERT_IMPL(a_hw_used_range, 1'b1, hw_used_q <= HwCntW'(HW_SLOTS))
  `DBSM_ASSERT_IMPL(a_one_cmd, 1'b1, $onehot0({sw_cmd_q, hw_cmd_q}))
  `DBSM_ASSERT_IMPL(a_load_from_build, $rose(out_valid_q), $past(state_q == StBuild))
  `DBSM_ASSERT_IMPL(a_hard_matches_dr7, out_valid_q, rsp_q.use_hard_bp == (rsp_q.dr7_image != '0))

endmodule
